>>> hw/rtl/sbpm_pkg.sv
package sbpm_pkg;

    localparam int PlaneLongTilesDefault = 128;

    localparam int CntW = 10;
    localparam int CoordW = 11;

    localparam logic [3:0] DetectReset = 4'd1;
    localparam logic [CoordW-1:0] VsyncOffset = 11'd22;
    localparam logic [CoordW-1:0] VertXOffset = 11'h010;
    localparam logic [7:0] ReadBase = 8'hfe;
    localparam logic [7:0] FlipMask = 8'hff;
    localparam logic [CoordW-1:0] ShortMask = 11'h0ff;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_PIXEL = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        PORT_CONTROL = 3'd0,
        PORT_CLEAR   = 3'd1,
        PORT_STEP    = 3'd2,
        PORT_ACK     = 3'd3,
        PORT_DISABLE = 3'd4,
        PORT_FIXED   = 3'd5
    } t_port;

    typedef struct packed {
        logic [7:0]      control;
        logic [CntW-1:0] h_count;
        logic [CntW-1:0] v_count;
        logic            flag;
        logic            bg_disable;
        logic [5:0]      fixed_color;
        logic [3:0]      detect;
    } t_state;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] port;
        logic [7:0] data;
        logic [7:0] screen_x;
        logic [7:0] screen_y;
        logic [5:0] fg_pen;
        logic [7:0] fg_color;
        logic [5:0] bg_pixel;
    } t_item;

endpackage

>>> hw/rtl/sbpm_regs.sv
module sbpm_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [3:0]       i_cfg_data,
    input  logic             i_fire,
    input  logic [1:0]       i_command,
    input  logic [2:0]       i_port,
    input  logic [7:0]       i_data,
    input  logic             i_set_flag,
    output sbpm_pkg::t_state o_cur,
    output sbpm_pkg::t_state o_nxt
);

    sbpm_pkg::t_state r_st;
    sbpm_pkg::t_state n_st;
    logic [sbpm_pkg::CntW-1:0] w_delta;

    always_comb begin
        n_st = r_st;
        w_delta = r_st.control[0] ? {sbpm_pkg::CntW{1'b1}} : sbpm_pkg::CntW'(1);
        if (i_cfg_we) begin
            n_st.detect = i_cfg_data;
        end
        if (i_fire) begin
            if (i_command == sbpm_pkg::CMD_WRITE) begin
                unique case (i_port)
                    sbpm_pkg::PORT_CONTROL: n_st.control = i_data;
                    sbpm_pkg::PORT_CLEAR: begin
                        n_st.h_count = '0;
                        n_st.v_count = '0;
                    end
                    sbpm_pkg::PORT_STEP: begin
                        if (r_st.control[1]) begin
                            n_st.v_count = r_st.v_count + w_delta;
                        end else begin
                            n_st.h_count = r_st.h_count + w_delta;
                        end
                    end
                    sbpm_pkg::PORT_ACK:     n_st.flag = 1'b0;
                    sbpm_pkg::PORT_DISABLE: n_st.bg_disable = i_data[0];
                    sbpm_pkg::PORT_FIXED:   n_st.fixed_color = i_data[5:0];
                    default: ;
                endcase
            end else if (i_command == sbpm_pkg::CMD_PIXEL && i_set_flag) begin
                n_st.flag = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.control     <= '0;
            r_st.h_count     <= '0;
            r_st.v_count     <= '0;
            r_st.flag        <= 1'b0;
            r_st.bg_disable  <= 1'b0;
            r_st.fixed_color <= '0;
            r_st.detect      <= sbpm_pkg::DetectReset;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_cur = r_st;
    assign o_nxt = n_st;

endmodule

>>> hw/rtl/sbpm_mix.sv
module sbpm_mix #(
    parameter int PLANE_LONG_TILES = sbpm_pkg::PlaneLongTilesDefault
) (
    input  sbpm_pkg::t_state      i_st,
    input  logic [1:0]            i_command,
    input  logic [7:0]            i_screen_x,
    input  logic [7:0]            i_screen_y,
    input  logic [5:0]            i_fg_pen,
    input  logic [7:0]            i_fg_color,
    input  logic [5:0]            i_bg_pixel,
    output logic [7:0]            o_read_data,
    output logic [sbpm_pkg::CntW-1:0] o_bg_x,
    output logic [sbpm_pkg::CntW-1:0] o_bg_y,
    output logic [6:0]            o_pixel_out,
    output logic                  o_set_flag
);

    localparam int LongDim = PLANE_LONG_TILES * 8;
    localparam logic [sbpm_pkg::CoordW-1:0] LongMask = sbpm_pkg::CoordW'(LongDim - 1);

    logic                          w_vert;
    logic [7:0]                    w_flip;
    logic [sbpm_pkg::CoordW-1:0]   w_sx;
    logic [sbpm_pkg::CoordW-1:0]   w_sy;
    logic [sbpm_pkg::CoordW-1:0]   w_ex;
    logic [sbpm_pkg::CoordW-1:0]   w_ey;
    logic [sbpm_pkg::CoordW-1:0]   w_xmask;
    logic [sbpm_pkg::CoordW-1:0]   w_ymask;
    logic [sbpm_pkg::CoordW-1:0]   w_bx;
    logic [sbpm_pkg::CoordW-1:0]   w_by;
    logic                          w_pix;

    always_comb begin
        w_vert  = i_st.control[1];
        w_flip  = i_st.control[0] ? sbpm_pkg::FlipMask : 8'h00;
        w_sx    = {3'b000, i_screen_x} + {1'b0, i_st.h_count};
        w_sy    = {3'b000, i_screen_y} + {1'b0, i_st.v_count} + sbpm_pkg::VsyncOffset;
        w_ex    = {w_sx[sbpm_pkg::CoordW-1:8], w_sx[7:0] ^ w_flip}
                  + (w_vert ? sbpm_pkg::VertXOffset : '0);
        w_ey    = {w_sy[sbpm_pkg::CoordW-1:8], w_sy[7:0] ^ w_flip};
        w_xmask = w_vert ? sbpm_pkg::ShortMask : LongMask;
        w_ymask = w_vert ? LongMask : sbpm_pkg::ShortMask;
        w_bx    = w_ex & w_xmask;
        w_by    = w_ey & w_ymask;
        w_pix   = (i_command == sbpm_pkg::CMD_PIXEL);

        o_read_data = (i_command == sbpm_pkg::CMD_READ)
                      ? (sbpm_pkg::ReadBase | {7'd0, i_st.flag}) : 8'h00;
        o_bg_x = w_pix ? w_bx[sbpm_pkg::CntW-1:0] : '0;
        o_bg_y = w_pix ? w_by[sbpm_pkg::CntW-1:0] : '0;
        o_set_flag = (i_bg_pixel != 6'd0) && (i_fg_color != 8'd0)
                     && (i_fg_pen[5:2] == i_st.detect);
        if (!w_pix) begin
            o_pixel_out = 7'd0;
        end else if (i_fg_color == 8'd0 && !i_st.bg_disable) begin
            o_pixel_out = {1'b1, i_bg_pixel | i_st.fixed_color};
        end else begin
            o_pixel_out = {1'b0, i_fg_pen};
        end
    end

endmodule

>>> hw/rtl/scrolling_background_port_and_mixer_core.sv
// Scrolling background port and pixel mixer. Each transaction is a port write,
// a port read or one pixel, and gives exactly one result. It is registered on
// input, resolved against board state combinationally and registered on output;
// its result is valid the cycle after it leaves the input register. One
// transaction can enter every cycle while the output is taken; while a result
// waits, the input register still takes one more transaction before input
// stalls. The result's control fields and collision flag reflect state after
// the transaction. The collision detect colour resets to 1 and is written on
// the config port by the user only when idle; the block does not enforce this.
module scrolling_background_port_and_mixer_core #(
    parameter int PLANE_LONG_TILES = sbpm_pkg::PlaneLongTilesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_port,
    input  logic [7:0]  i_data,
    input  logic [7:0]  i_screen_x,
    input  logic [7:0]  i_screen_y,
    input  logic [5:0]  i_fg_pen,
    input  logic [7:0]  i_fg_color,
    input  logic [5:0]  i_bg_pixel,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic [9:0]  o_bg_x,
    output logic [9:0]  o_bg_y,
    output logic        o_plane_select,
    output logic [1:0]  o_rom_select,
    output logic        o_char_bank,
    output logic [6:0]  o_pixel_out,
    output logic        o_collision
);

    logic              r_in_valid;
    logic [1:0]        r_command;
    logic [2:0]        r_port;
    logic [7:0]        r_data;
    logic [7:0]        r_screen_x;
    logic [7:0]        r_screen_y;
    logic [5:0]        r_fg_pen;
    logic [7:0]        r_fg_color;
    logic [5:0]        r_bg_pixel;

    logic              r_out_valid;
    logic [7:0]        r_read_data;
    logic [9:0]        r_bg_x;
    logic [9:0]        r_bg_y;
    logic              r_plane_select;
    logic [1:0]        r_rom_select;
    logic              r_char_bank;
    logic [6:0]        r_pixel_out;
    logic              r_collision;

    logic              w_adv;
    logic              w_load;
    logic              w_set_flag;
    logic [7:0]        w_read_data;
    logic [9:0]        w_bg_x;
    logic [9:0]        w_bg_y;
    logic [6:0]        w_pixel_out;
    sbpm_pkg::t_state  w_cur;
    sbpm_pkg::t_state  w_nxt;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_load     = i_in_valid && o_in_ready;

    sbpm_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (w_adv),
        .i_command  (r_command),
        .i_port     (r_port),
        .i_data     (r_data),
        .i_set_flag (w_set_flag),
        .o_cur      (w_cur),
        .o_nxt      (w_nxt)
    );

    sbpm_mix #(
        .PLANE_LONG_TILES (PLANE_LONG_TILES)
    ) u_mix (
        .i_st        (w_cur),
        .i_command   (r_command),
        .i_screen_x  (r_screen_x),
        .i_screen_y  (r_screen_y),
        .i_fg_pen    (r_fg_pen),
        .i_fg_color  (r_fg_color),
        .i_bg_pixel  (r_bg_pixel),
        .o_read_data (w_read_data),
        .o_bg_x      (w_bg_x),
        .o_bg_y      (w_bg_y),
        .o_pixel_out (w_pixel_out),
        .o_set_flag  (w_set_flag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_command  <= i_command;
            r_port     <= i_port;
            r_data     <= i_data;
            r_screen_x <= i_screen_x;
            r_screen_y <= i_screen_y;
            r_fg_pen   <= i_fg_pen;
            r_fg_color <= i_fg_color;
            r_bg_pixel <= i_bg_pixel;
        end
        if (w_adv) begin
            r_read_data    <= w_read_data;
            r_bg_x         <= w_bg_x;
            r_bg_y         <= w_bg_y;
            r_plane_select <= w_nxt.control[1];
            r_rom_select   <= w_nxt.control[7:6];
            r_char_bank    <= w_nxt.control[2];
            r_pixel_out    <= w_pixel_out;
            r_collision    <= w_nxt.flag;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_read_data;
    assign o_bg_x         = r_bg_x;
    assign o_bg_y         = r_bg_y;
    assign o_plane_select = r_plane_select;
    assign o_rom_select   = r_rom_select;
    assign o_char_bank    = r_char_bank;
    assign o_pixel_out    = r_pixel_out;
    assign o_collision    = r_collision;

endmodule
